// ===== hdl/prt_pkg.sv =====
`default_nettype none
package prt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int SRV_MAX = 127;

	localparam logic [1:0] OP_POLL = 2'd0;
	localparam logic [1:0] OP_ADD = 2'd1;
	localparam logic [1:0] OP_RESP = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [1:0] KIND_SERVER = 2'd0;
	localparam logic [1:0] KIND_MASTER = 2'd1;
	localparam logic [1:0] KIND_BCAST = 2'd2;
	localparam logic [1:0] KIND_OTHER = 2'd3;

	localparam logic [1:0] PH_QUEUED = 2'd0;
	localparam logic [1:0] PH_QUERIED = 2'd1;
	localparam logic [1:0] PH_RESPONDED = 2'd2;
	localparam logic [1:0] PH_NORESP = 2'd3;

	localparam logic [1:0] REG_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_MAX_ATT = 2'd1;
	localparam logic [1:0] REG_SPACING = 2'd2;

	localparam logic [15:0] TIMEOUT_RST = 16'd2000;
	localparam logic [3:0] MAX_ATT_RST = 4'd3;
	localparam logic [15:0] SPACING_RST = 16'd50;
	localparam logic [3:0] ATT_SAT = 4'd15;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] now_ms;
		logic [47:0] peer_addr;
		logic [1:0]  peer_kind;
		logic        header_ok;
	} in_t;

	typedef struct packed {
		logic        probe_sent;
		logic [1:0]  probe_kind;
		logic [47:0] probe_addr;
		logic        answered;
		logic [47:0] answered_addr;
		logic [31:0] round_trip_ms;
		logic        gave_up;
		logic        all_done;
		logic [6:0]  server_responses;
		logic        table_full;
	} out_t;

	typedef struct packed {
		logic [47:0] addr;
		logic [1:0]  kind;
		logic [1:0]  phase;
		logic [31:0] ptime;
		logic [3:0]  att;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic load;
		logic rewind;
		logic rd_en;
		logic decide;
		logic stat;
	} ctl_cmd_t;

	typedef struct packed {
		logic scan_end;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== hdl/prt_ram.sv =====
`default_nettype none
module prt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== hdl/prt_ctrl.sv =====
`default_nettype none
module prt_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire prt_pkg::dp_stat_t st,
	output prt_pkg::ctl_cmd_t      cmd,
	output logic                   busy,
	output logic                   done
);
	import prt_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SCAN   = 5'b00010,
		S_DECIDE = 5'b00100,
		S_STAT   = 5'b01000,
		S_FIN    = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					cmd.rewind = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (!st.scan_end) begin
					cmd.rd_en = 1'b1;
				end else begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				cmd.rewind = 1'b1;
				state_d = S_STAT;
			end
			S_STAT: begin
				cmd.stat = 1'b1;
				if (!st.scan_end) begin
					cmd.rd_en = 1'b1;
				end else begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_FIN);
endmodule
`default_nettype wire

// ===== hdl/prt_datapath.sv =====
`default_nettype none
module prt_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire prt_pkg::ctl_cmd_t cmd,
	input  wire prt_pkg::in_t      item,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_idx,
	input  wire logic [15:0]       cfg_data,
	output prt_pkg::dp_stat_t      st,
	output prt_pkg::out_t          result
);
	import prt_pkg::*;

	// latched item
	logic [1:0]  op_q;
	logic [31:0] now_q;
	logic [47:0] addr_q;
	logic [1:0]  kind_q;
	logic        hdr_q;

	logic [15:0] timeout_q;
	logic [3:0]  max_att_q;
	logic [15:0] spacing_q;

	logic [CNT_W-1:0] count_q;
	logic [31:0]      last_send_q;
	logic [CNT_W-1:0] ptr_q;
	logic             ev_s1;
	logic [IDX_W-1:0] ev_idx_s1;

	logic             gave_q;
	logic             cand_found_q, match_found_q, bc_found_q;
	logic [IDX_W-1:0] cand_idx_q, match_idx_q;
	entry_t           cand_q, match_q, bc_q;
	logic             done_acc_q;
	logic [CNT_W-1:0] srv_q;

	logic        probe_sent_q, answered_q, full_q;
	logic [1:0]  probe_kind_q;
	logic [47:0] probe_addr_q;
	logic [31:0] rtt_q;

	entry_t           rd_ent;
	logic             timed_out, give, cand;
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	entry_t           wr_ent;
	logic             room, spacing_ok;
	logic [31:0]      cand_diff;

	logic             dec_wr;
	logic [IDX_W-1:0] dec_idx;
	entry_t           dec_ent;
	logic             dec_append, dec_full, dec_probe, dec_ans;
	logic [31:0]      dec_rtt;

	prt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_idx),
		.wdata (wr_ent),
		.re    (cmd.rd_en),
		.raddr (ptr_q[IDX_W-1:0]),
		.rdata (rd_ent)
	);

	assign st.scan_end = (ptr_q >= count_q);
	assign room = (count_q < CNT_W'(TABLE_DEPTH));
	assign cand_diff = now_q - last_send_q;
	assign spacing_ok = (cand_diff >= {16'd0, spacing_q});

	// per-entry evaluation during the lookup pass
	always_comb begin
		timed_out = ((now_q - rd_ent.ptime) > {16'd0, timeout_q});
		give = ev_s1 && !cmd.stat && (op_q == OP_POLL) && (rd_ent.phase == PH_QUERIED)
			&& (rd_ent.att >= max_att_q) && timed_out;
		cand = (op_q == OP_POLL) && !give && ((rd_ent.phase == PH_QUEUED)
			|| ((rd_ent.phase == PH_QUERIED) && timed_out));
	end

	// at most one table update per item at decide; give-up writes come in the lookup pass
	always_comb begin
		dec_wr = 1'b0;
		dec_idx = count_q[IDX_W-1:0];
		dec_ent = '0;
		dec_append = 1'b0;
		dec_full = 1'b0;
		dec_probe = 1'b0;
		dec_ans = 1'b0;
		dec_rtt = '0;
		case (op_q)
			OP_POLL: begin
				if (spacing_ok && cand_found_q) begin
					dec_probe = 1'b1;
					dec_wr = 1'b1;
					dec_idx = cand_idx_q;
					dec_ent = cand_q;
					dec_ent.phase = PH_QUERIED;
					dec_ent.ptime = now_q;
					dec_ent.att = (cand_q.att == ATT_SAT) ? cand_q.att : cand_q.att + 4'd1;
				end
			end
			OP_ADD: begin
				if ((kind_q == KIND_BCAST) ? !bc_found_q : !match_found_q) begin
					if (room) begin
						dec_wr = 1'b1;
						dec_append = 1'b1;
						dec_ent.addr = (kind_q == KIND_BCAST) ? 48'd0 : addr_q;
						dec_ent.kind = kind_q;
						dec_ent.phase = PH_QUEUED;
					end else begin
						dec_full = 1'b1;
					end
				end
			end
			OP_RESP: begin
				if (match_found_q && match_q.kind == KIND_MASTER) begin
					if (hdr_q) begin
						dec_wr = 1'b1;
						dec_idx = match_idx_q;
						dec_ent = match_q;
						dec_ent.phase = PH_RESPONDED;
					end
				end else if (hdr_q) begin
					if (match_found_q) begin
						if (match_q.phase != PH_RESPONDED) begin
							dec_wr = 1'b1;
							dec_idx = match_idx_q;
							dec_ent = match_q;
							dec_ent.phase = PH_RESPONDED;
							dec_ans = 1'b1;
							dec_rtt = now_q - match_q.ptime;
						end
					end else if (bc_found_q && bc_q.phase == PH_QUERIED) begin
						if (room) begin
							// learned responder, answered at once
							dec_wr = 1'b1;
							dec_append = 1'b1;
							dec_ent.addr = addr_q;
							dec_ent.kind = KIND_SERVER;
							dec_ent.phase = PH_RESPONDED;
							dec_ent.ptime = bc_q.ptime;
							dec_ans = 1'b1;
							dec_rtt = now_q - bc_q.ptime;
						end else begin
							dec_full = 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (cmd.decide) begin
			wr_en = dec_wr;
			wr_idx = dec_idx;
			wr_ent = dec_ent;
		end else begin
			wr_en = give;
			wr_idx = ev_idx_s1;
			wr_ent = rd_ent;
			wr_ent.phase = PH_NORESP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			max_att_q <= MAX_ATT_RST;
			spacing_q <= SPACING_RST;
			count_q <= '0;
			last_send_q <= '0;
			ptr_q <= '0;
			ev_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_TIMEOUT: timeout_q <= cfg_data;
					REG_MAX_ATT: max_att_q <= cfg_data[3:0];
					REG_SPACING: spacing_q <= cfg_data;
					default: begin
					end
				endcase
			end
			ev_s1 <= cmd.rd_en;
			if (cmd.rewind) begin
				ptr_q <= '0;
			end else if (cmd.rd_en) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end
			if (cmd.decide) begin
				if (op_q == OP_CLEAR) begin
					count_q <= '0;
				end else if (dec_append) begin
					count_q <= count_q + CNT_W'(1);
				end
				if (dec_probe) begin
					last_send_q <= now_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		ev_idx_s1 <= ptr_q[IDX_W-1:0];
		if (cmd.load) begin
			op_q <= item.operation;
			now_q <= item.now_ms;
			addr_q <= item.peer_addr;
			kind_q <= (item.peer_kind == KIND_OTHER) ? KIND_SERVER : item.peer_kind;
			hdr_q <= item.header_ok;
			gave_q <= 1'b0;
			cand_found_q <= 1'b0;
			match_found_q <= 1'b0;
			bc_found_q <= 1'b0;
			done_acc_q <= 1'b1;
			srv_q <= '0;
			probe_sent_q <= 1'b0;
			answered_q <= 1'b0;
			full_q <= 1'b0;
		end
		if (ev_s1 && !cmd.stat) begin
			if (give) begin
				gave_q <= 1'b1;
			end
			if (cand && !cand_found_q) begin
				cand_found_q <= 1'b1;
				cand_idx_q <= ev_idx_s1;
				cand_q <= rd_ent;
			end
			if (rd_ent.kind != KIND_BCAST && rd_ent.addr == addr_q && !match_found_q) begin
				match_found_q <= 1'b1;
				match_idx_q <= ev_idx_s1;
				match_q <= rd_ent;
			end
			if (rd_ent.kind == KIND_BCAST && !bc_found_q) begin
				bc_found_q <= 1'b1;
				bc_q <= rd_ent;
			end
		end
		if (ev_s1 && cmd.stat) begin
			if (rd_ent.phase != PH_RESPONDED && rd_ent.phase != PH_NORESP) begin
				done_acc_q <= 1'b0;
			end
			if (rd_ent.kind == KIND_SERVER && rd_ent.phase == PH_RESPONDED) begin
				srv_q <= srv_q + CNT_W'(1);
			end
		end
		if (cmd.decide) begin
			probe_sent_q <= dec_probe;
			probe_kind_q <= cand_q.kind;
			probe_addr_q <= cand_q.addr;
			answered_q <= dec_ans;
			rtt_q <= dec_rtt;
			full_q <= dec_full;
		end
	end

	always_comb begin
		result = '0;
		result.probe_sent = probe_sent_q;
		result.probe_kind = probe_sent_q ? probe_kind_q : 2'd0;
		result.probe_addr = (probe_sent_q && probe_kind_q != KIND_BCAST) ? probe_addr_q : 48'd0;
		result.answered = answered_q;
		result.answered_addr = answered_q ? addr_q : 48'd0;
		result.round_trip_ms = answered_q ? rtt_q : 32'd0;
		result.gave_up = gave_q;
		result.all_done = done_acc_q;
		result.server_responses = (srv_q > CNT_W'(SRV_MAX)) ? 7'(SRV_MAX) : srv_q[6:0];
		result.table_full = full_q;
	end
endmodule
`default_nettype wire

// ===== hdl/probe_retry_tracker.sv =====
// flow: start to done runs one lookup pass over the N0 entries held before the item and one
//   statistics pass over the N entries held after it, one ram read per cycle
// a new item is taken only while idle; busy stays high through the result beat
// result beat: done high for one cycle with result; the receiver cannot stall
// reset: arst_n async low clears the table count, last send time, registers to defaults
`default_nettype none
module probe_retry_tracker (
	input  wire logic          clk,
	input  wire logic          arst_n,
	// command side
	input  wire logic          start,
	output logic               busy,
	input  wire prt_pkg::in_t  item,
	// result side, one beat per item
	output logic               done,
	output prt_pkg::out_t      result,
	// configuration writes, to be made only while idle; the block does not enforce it
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_idx,
	input  wire logic [15:0]   cfg_data
);
	import prt_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t st;
	logic     ctl_busy;

	// sequencer: idle, lookup pass, table update, statistics pass, result beat
	prt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (ctl_busy),
		.done   (done)
	);

	// entry table in ram plus scan accumulators and result registers
	prt_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.st       (st),
		.result   (result)
	);

	assign busy = ctl_busy;
endmodule
`default_nettype wire

// ===== hdl/prt_checker.sv =====
`default_nettype none
module prt_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         start,
	input wire logic         busy,
	input wire logic         done,
	input wire prt_pkg::out_t result
);
	// a result beat lasts one cycle
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done longer than one cycle");

	// accepted item makes the block busy
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("item accepted but not busy");

	// result only while an item is in flight
	assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("done while idle");

	// unused probe address reads zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.probe_sent) |-> (result.probe_addr == 48'd0))
		else $error("probe address without probe");
endmodule

bind probe_retry_tracker prt_checker u_prt_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
`default_nettype wire

// ===== tb/probe_retry_tracker_test.sv =====
`timescale 1ns / 100ps
`default_nettype none
module probe_retry_tracker_test;
	import prt_pkg::*;

	localparam int N_RANDOM = 1500;
	localparam int WATCHDOG = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_t item = '0;
	logic done;
	out_t result;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_idx = '0;
	logic [15:0] cfg_data = '0;

	probe_retry_tracker uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// predictor copy of the target table
	logic [47:0] tbl_addr [TABLE_DEPTH];
	logic [1:0] tbl_kind [TABLE_DEPTH];
	logic [1:0] tbl_phase [TABLE_DEPTH];
	logic [31:0] tbl_ptime [TABLE_DEPTH];
	logic [3:0] tbl_att [TABLE_DEPTH];
	int tbl_count;
	logic [31:0] last_send;
	logic [15:0] cur_timeout;
	logic [3:0] cur_max_att;
	logic [15:0] cur_spacing;

	out_t pending_results[$];
	int errors = 0;
	int idle_cycles = 0;
	logic idle_free = 1'b0;
	logic [31:0] clock_ms = 0;

	function automatic int find_addr(logic [47:0] a);
		for (int i = 0; i < tbl_count; i++)
			if (tbl_kind[i] != KIND_BCAST && tbl_addr[i] == a) return i;
		return -1;
	endfunction

	function automatic int find_bcast();
		for (int i = 0; i < tbl_count; i++)
			if (tbl_kind[i] == KIND_BCAST) return i;
		return -1;
	endfunction

	function automatic int append_target(logic [47:0] a, logic [1:0] k);
		if (tbl_count >= TABLE_DEPTH) return -1;
		tbl_addr[tbl_count] = a;
		tbl_kind[tbl_count] = k;
		tbl_phase[tbl_count] = PH_QUEUED;
		tbl_ptime[tbl_count] = '0;
		tbl_att[tbl_count] = '0;
		tbl_count++;
		return tbl_count - 1;
	endfunction

	function automatic logic probe_expired(int i, logic [31:0] now);
		logic [31:0] d;
		d = now - tbl_ptime[i];
		return d > {16'd0, cur_timeout};
	endfunction

	// works out the result beat of one item and updates the table copy
	function automatic out_t track_item(in_t it);
		out_t r;
		int i, k, b, srv;
		logic [1:0] kd;
		logic fin;
		logic [31:0] gap;
		r = '0;
		srv = 0;
		fin = 1'b1;
		case (it.operation)
			OP_POLL: begin
				for (i = 0; i < tbl_count; i++)
					if (tbl_phase[i] == PH_QUERIED && tbl_att[i] >= cur_max_att
							&& probe_expired(i, it.now_ms)) begin
						tbl_phase[i] = PH_NORESP;
						r.gave_up = 1'b1;
					end
				gap = it.now_ms - last_send;
				if (gap >= {16'd0, cur_spacing}) begin
					for (i = 0; i < tbl_count; i++)
						if (tbl_phase[i] == PH_QUEUED || (tbl_phase[i] == PH_QUERIED
								&& probe_expired(i, it.now_ms))) break;
					if (i < tbl_count) begin
						r.probe_sent = 1'b1;
						r.probe_kind = tbl_kind[i];
						r.probe_addr = tbl_kind[i] == KIND_BCAST ? '0 : tbl_addr[i];
						tbl_phase[i] = PH_QUERIED;
						tbl_ptime[i] = it.now_ms;
						if (tbl_att[i] < ATT_SAT) tbl_att[i]++;
						last_send = it.now_ms;
					end
				end
			end
			OP_ADD: begin
				kd = it.peer_kind == KIND_OTHER ? KIND_SERVER : it.peer_kind;
				if (kd == KIND_BCAST) begin
					if (find_bcast() < 0 && append_target('0, KIND_BCAST) < 0)
						r.table_full = 1'b1;
				end else if (find_addr(it.peer_addr) < 0) begin
					if (append_target(it.peer_addr, kd) < 0) r.table_full = 1'b1;
				end
			end
			OP_RESP: begin
				k = find_addr(it.peer_addr);
				if (k >= 0 && tbl_kind[k] == KIND_MASTER) begin
					if (it.header_ok) tbl_phase[k] = PH_RESPONDED;
				end else if (it.header_ok) begin
					if (k < 0) begin
						b = find_bcast();
						if (b >= 0 && tbl_phase[b] == PH_QUERIED) begin
							k = append_target(it.peer_addr, KIND_SERVER);
							if (k < 0) r.table_full = 1'b1;
							else begin
								tbl_phase[k] = PH_QUERIED;
								tbl_ptime[k] = tbl_ptime[b];
							end
						end
					end
					if (k >= 0 && tbl_phase[k] != PH_RESPONDED) begin
						tbl_phase[k] = PH_RESPONDED;
						r.answered = 1'b1;
						r.answered_addr = it.peer_addr;
						r.round_trip_ms = it.now_ms - tbl_ptime[k];
					end
				end
			end
			default: tbl_count = 0;
		endcase
		for (i = 0; i < tbl_count; i++) begin
			if (tbl_phase[i] != PH_RESPONDED && tbl_phase[i] != PH_NORESP) fin = 1'b0;
			if (tbl_kind[i] == KIND_SERVER && tbl_phase[i] == PH_RESPONDED) srv++;
		end
		r.all_done = fin;
		r.server_responses = srv > SRV_MAX ? 7'(SRV_MAX) : 7'(srv);
		return r;
	endfunction

	// result side: compare every beat with the oldest expectation
	always @(posedge clk) begin
		out_t want;
		if (start && !busy) idle_cycles <= 0;
		else if (done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (done) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (result.probe_sent !== want.probe_sent)
					$error("probe_sent exp %0h got %0h", want.probe_sent, result.probe_sent);
				if (result.probe_kind !== want.probe_kind)
					$error("probe_kind exp %0h got %0h", want.probe_kind, result.probe_kind);
				if (result.probe_addr !== want.probe_addr)
					$error("probe_addr exp %0h got %0h", want.probe_addr, result.probe_addr);
				if (result.answered !== want.answered)
					$error("answered exp %0h got %0h", want.answered, result.answered);
				if (result.answered_addr !== want.answered_addr)
					$error("answered_addr exp %0h got %0h", want.answered_addr,
						result.answered_addr);
				if (result.round_trip_ms !== want.round_trip_ms)
					$error("round_trip_ms exp %0h got %0h", want.round_trip_ms,
						result.round_trip_ms);
				if (result.gave_up !== want.gave_up)
					$error("gave_up exp %0h got %0h", want.gave_up, result.gave_up);
				if (result.all_done !== want.all_done)
					$error("all_done exp %0h got %0h", want.all_done, result.all_done);
				if (result.server_responses !== want.server_responses)
					$error("server_responses exp %0d got %0d", want.server_responses,
						result.server_responses);
				if (result.table_full !== want.table_full)
					$error("table_full exp %0h got %0h", want.table_full, result.table_full);
				if (result !== want) errors++;
			end
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if (idle_cycles > WATCHDOG) begin
			$display("FAIL");
			$finish;
		end
	end

	// writes one register and updates the predictor's copy of the setting
	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TIMEOUT: cur_timeout = val;
			REG_MAX_ATT: cur_max_att = val[3:0];
			default: cur_spacing = val;
		endcase
	endtask

	task automatic drain();
		while (pending_results.size() != 0) @(negedge clk);
		repeat (140) @(negedge clk);
	endtask

	// one beat on the command side; expectation is queued at acceptance
	task automatic issue(in_t it, logic chk, out_t fixed);
		out_t pred;
		@(negedge clk);
		if (!idle_free && $urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 13)) @(negedge clk);
		item <= it;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		pred = track_item(it);
		pending_results.push_back(pred);
		if (chk && pred !== fixed) begin
			$error("table row disagrees with predictor: exp %0h pred %0h", fixed, pred);
			errors++;
		end
		@(negedge clk);
		start <= 1'b0;
	endtask

	function automatic in_t mk(logic [1:0] op, logic [31:0] t, logic [47:0] a,
			logic [1:0] k, logic h);
		in_t it;
		it.operation = op;
		it.now_ms = t;
		it.peer_addr = a;
		it.peer_kind = k;
		it.header_ok = h;
		return it;
	endfunction

	// pool of addresses so that responses hit known entries often
	logic [47:0] addr_pool [16];

	task automatic random_item(int focus);
		in_t it;
		int r;
		r = $urandom_range(0, 99);
		clock_ms += $urandom_range(0, focus);
		if (r < 40) it = mk(OP_POLL, clock_ms, '0, KIND_SERVER, 1'b0);
		else if (r < 62) it = mk(OP_ADD, clock_ms, addr_pool[$urandom_range(0, 15)],
			2'($urandom_range(0, 3)), 1'($urandom));
		else if (r < 95) it = mk(OP_RESP, clock_ms,
			($urandom_range(0, 4) == 0) ? {$urandom, 16'($urandom)}
				: addr_pool[$urandom_range(0, 15)],
			2'($urandom_range(0, 3)), $urandom_range(0, 5) != 0);
		else if (r < 97) it = mk(OP_CLEAR, clock_ms, '0, KIND_SERVER, 1'b0);
		else it = mk(2'($urandom), {$urandom}, {$urandom, 16'($urandom)},
			2'($urandom), 1'($urandom));
		if (it.operation == OP_POLL && $urandom_range(0, 20) == 0) it.now_ms = $urandom;
		issue(it, 1'b0, '0);
	endtask

	typedef struct {
		in_t it;
		logic chk;
		out_t want;
	} row_t;

	initial begin
		row_t rows [$];
		out_t w;
		in_t it;
		logic [47:0] amax;
		amax = '1;
		cur_timeout = TIMEOUT_RST;
		cur_max_att = MAX_ATT_RST;
		cur_spacing = SPACING_RST;
		tbl_count = 0;
		last_send = '0;
		for (int i = 0; i < 16; i++) addr_pool[i] = {$urandom, 16'($urandom)};
		addr_pool[0] = '0;
		addr_pool[1] = amax;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table; checked rows carry typed results
		w = '0; w.all_done = 1'b1;
		rows.push_back('{mk(OP_POLL, 32'd0, '0, KIND_SERVER, 1'b0), 1'b1, w});
		rows.push_back('{mk(OP_RESP, 32'd5, amax, KIND_SERVER, 1'b1), 1'b1, w});
		w = '0;
		rows.push_back('{mk(OP_ADD, 32'd1, amax, KIND_OTHER, 1'b0), 1'b1, w});
		rows.push_back('{mk(OP_ADD, 32'd1, amax, KIND_MASTER, 1'b0), 1'b1, w});
		rows.push_back('{mk(OP_ADD, 32'd2, '0, KIND_MASTER, 1'b0), 1'b0, w});
		rows.push_back('{mk(OP_ADD, 32'd3, 48'h123, KIND_BCAST, 1'b0), 1'b0, w});
		rows.push_back('{mk(OP_ADD, 32'd3, 48'h456, KIND_BCAST, 1'b0), 1'b0, w});
		// never-probed server answers: round trip is the time itself
		w.answered = 1'b1; w.answered_addr = amax; w.round_trip_ms = '1;
		w.server_responses = 7'd1;
		rows.push_back('{mk(OP_RESP, 32'hffff_ffff, amax, KIND_SERVER, 1'b1), 1'b1, w});
		rows.push_back('{mk(OP_POLL, 32'd100, '0, KIND_SERVER, 1'b0), 1'b0, w});
		rows.push_back('{mk(OP_POLL, 32'd200, '0, KIND_SERVER, 1'b0), 1'b0, w});
		rows.push_back('{mk(OP_RESP, 32'd250, 48'hab, KIND_SERVER, 1'b1), 1'b0, w});
		rows.push_back('{mk(OP_RESP, 32'd260, 48'hab, KIND_SERVER, 1'b1), 1'b0, w});
		rows.push_back('{mk(OP_RESP, 32'd270, '0, KIND_SERVER, 1'b0), 1'b0, w});
		rows.push_back('{mk(OP_RESP, 32'd280, '0, KIND_SERVER, 1'b1), 1'b0, w});
		for (int i = 0; i < 4; i++)
			rows.push_back('{mk(OP_POLL, 32'd3000 * (i + 1), '0, KIND_SERVER, 1'b0),
				1'b0, w});
		w = '0; w.all_done = 1'b1;
		rows.push_back('{mk(OP_CLEAR, 32'd20000, '0, KIND_SERVER, 1'b0), 1'b1, w});
		foreach (rows[i]) issue(rows[i].it, rows[i].chk, rows[i].want);
		drain();

		// fill the table to hit the full flag
		write_reg(REG_SPACING, 16'd0);
		write_reg(REG_TIMEOUT, 16'd0);
		write_reg(REG_MAX_ATT, 16'd1);
		for (int i = 0; i < TABLE_DEPTH + 2; i++)
			issue(mk(OP_ADD, 32'd1, 48'(i + 1), 2'($urandom_range(0, 1)), 1'b0),
				1'b0, '0);
		issue(mk(OP_ADD, 32'd1, '0, KIND_BCAST, 1'b0), 1'b0, '0);
		for (int i = 0; i < 8; i++)
			issue(mk(OP_POLL, 32'd10 + i, '0, KIND_SERVER, 1'b0), 1'b0, '0);
		issue(mk(OP_CLEAR, 32'd0, '0, KIND_SERVER, 1'b0), 1'b0, '0);
		// broadcast learning until the table overflows
		issue(mk(OP_ADD, 32'd1, '0, KIND_BCAST, 1'b0), 1'b0, '0);
		issue(mk(OP_POLL, 32'd40, '0, KIND_SERVER, 1'b0), 1'b0, '0);
		for (int i = 0; i < TABLE_DEPTH + 1; i++)
			issue(mk(OP_RESP, 32'd90, {$urandom, 16'($urandom)}, KIND_SERVER, 1'b1),
				1'b0, '0);
		issue(mk(OP_CLEAR, 32'd0, '0, KIND_SERVER, 1'b0), 1'b0, '0);
		drain();

		// random phases over several settings, extremes among them
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(REG_TIMEOUT, 16'd2000); write_reg(REG_MAX_ATT, 16'd3);
					write_reg(REG_SPACING, 16'd50); end
				1: begin write_reg(REG_TIMEOUT, 16'd0); write_reg(REG_MAX_ATT, 16'd0);
					write_reg(REG_SPACING, 16'd0); end
				2: begin write_reg(REG_TIMEOUT, 16'hffff); write_reg(REG_MAX_ATT, 16'd15);
					write_reg(REG_SPACING, 16'hffff); end
				3: begin write_reg(REG_TIMEOUT, 16'd100); write_reg(REG_MAX_ATT, 16'd1);
					write_reg(REG_SPACING, 16'd10); end
				4: begin write_reg(REG_TIMEOUT, 16'($urandom));
					write_reg(REG_MAX_ATT, 16'($urandom_range(0, 15)));
					write_reg(REG_SPACING, 16'($urandom_range(0, 300))); end
				default: begin write_reg(REG_TIMEOUT, 16'd500);
					write_reg(REG_MAX_ATT, 16'd2); write_reg(REG_SPACING, 16'd20); end
			endcase
			// last phase runs with no idle gaps
			idle_free = (ph == 5);
			for (int n = 0; n < N_RANDOM / 6; n++) begin
				random_item(ph == 2 ? 40000 : 700);
				// at item 100 the sender holds off until all results are in
				if (n == 100) while (pending_results.size() != 0) @(negedge clk);
			end
			drain();
		end

		if (errors == 0 && pending_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
hdl/prt_pkg.sv
hdl/prt_ram.sv
hdl/prt_ctrl.sv
hdl/prt_datapath.sv
hdl/probe_retry_tracker.sv
hdl/prt_checker.sv
tb/probe_retry_tracker_test.sv
